// ===== src/tx_power_map_and_pa_bias_assert.svh =====
// ----------------------------------------------------------------------------
// tx power map assertion macros
// shorthand for clocked implication checks with an active-low reset
// ----------------------------------------------------------------------------
`ifndef TX_POWER_MAP_AND_PA_BIAS_ASSERT_SVH
`define TX_POWER_MAP_AND_PA_BIAS_ASSERT_SVH

// same-cycle implication
`define TXPM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TXPM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/txpm_pkg.sv =====
// ----------------------------------------------------------------------------
// txpm_pkg
// shared types, constants and field helpers of the transmit power mapper
// ----------------------------------------------------------------------------
package txpm_pkg;

  localparam int NumPointsDef = 7;
  localparam int MaxPoints    = 8;
  localparam int NumRegs      = 7;
  localparam int ApbAddrWidth = 5;
  localparam int ApbDataWidth = 32;
  localparam int RegIdxWidth  = 3;
  localparam int PointWidth   = 24;

  // divider geometry: magnitude of the rounded numerator over an 8 bit span
  localparam int DivNumWidth  = 17;
  localparam int DivDenWidth  = 8;
  localparam int DivCntWidth  = 5;

  typedef logic [1:0] op_t;
  localparam op_t OpMap      = 2'd0;
  localparam op_t OpTxEnable = 2'd1;
  localparam op_t OpRxIdle   = 2'd2;

  typedef logic [PointWidth-1:0] point_t;

  // the eighth point repeats the last one and has no register
  localparam point_t PointReset [MaxPoints] = '{
    24'd7925514, 24'd7925774, 24'd7926289, 24'd7927060,
    24'd7928088, 24'd7929115, 24'd6227230, 24'd6227230
  };

  typedef struct packed {
    logic                   start;
    logic [DivNumWidth-1:0] dividend;
    logic [DivDenWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [DivNumWidth-1:0] quotient;
  } div_rsp_t;

  function automatic logic signed [7:0] pt_total(point_t p);
    return p[7:0];
  endfunction

  function automatic logic signed [7:0] pt_chip(point_t p);
    return p[15:8];
  endfunction

  function automatic logic [7:0] pt_bias(point_t p);
    return p[23:16];
  endfunction

endpackage

// ===== src/txpm_div.sv =====
// ----------------------------------------------------------------------------
// txpm_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module txpm_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  txpm_pkg::div_req_t  req_i,
  output txpm_pkg::div_rsp_t  rsp_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [txpm_pkg::DivCntWidth-1:0]    cnt_q, cnt_d;
  logic [txpm_pkg::DivNumWidth-1:0]    quo_q, quo_d;
  logic [txpm_pkg::DivDenWidth-1:0]    rem_q, rem_d;
  logic [txpm_pkg::DivDenWidth-1:0]    den_q, den_d;
  logic [txpm_pkg::DivDenWidth:0]      rem_sh;
  logic [txpm_pkg::DivDenWidth:0]      rem_sub;
  logic                                ge;

  assign rem_sh  = {rem_q, quo_q[txpm_pkg::DivNumWidth-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits the low bits
      rem_d = ge ? rem_sub[txpm_pkg::DivDenWidth-1:0] : rem_sh[txpm_pkg::DivDenWidth-1:0];
      quo_d = {quo_q[txpm_pkg::DivNumWidth-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == txpm_pkg::DivCntWidth'(txpm_pkg::DivNumWidth - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== src/tx_power_map_and_pa_bias.sv =====
// ----------------------------------------------------------------------------
// tx_power_map_and_pa_bias
// transmit power mapper with calibration table and amplifier bias driver
// ----------------------------------------------------------------------------
// usage:
//   request channel: in_valid_i / in_stall_o carry operation_i and
//   requested_dbm_i; a request is taken when valid is high and stall is low
//   result channel: out_valid_o / out_stall_i carry chip_dbm_o, chip_valid_o
//   and dac_level_o, exactly one result per request
//   calibration points sit behind an apb-style port at byte address 4*i; the
//   user writes them only while the block is idle (not enforced); pready is always high
// request flow (states passed from the accepting edge to the result):
//   one request at a time; stall stays high until its result is registered,
//   and the next request is taken once the sequencer is back in idle
//   transmit enable, receive/idle and clamped map requests: start, out
//   map request on a flat or falling segment: start, scan, out
//   interpolated map requests: start, scan, multiply, add, divide, fix, out;
//   scan steps once per segment scanned (1 .. NumPoints-1), and divide waits
//   on the bit-serial divider, which forms the 17 quotient bits
// reset: table back to its factory points, latched and driven bias 0,
//   no result pending
// receiver stall: a finished result waits in the output register; the next
//   request may be taken meanwhile and its own result waits for the slot
// ----------------------------------------------------------------------------
module tx_power_map_and_pa_bias #(
  parameter int NumPoints = txpm_pkg::NumPointsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         operation_i,
  input  logic signed [7:0]                  requested_dbm_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [7:0]                  chip_dbm_o,
  output logic                               chip_valid_o,
  output logic [7:0]                         dac_level_o,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [txpm_pkg::ApbAddrWidth-1:0]  paddr,
  input  logic [txpm_pkg::ApbDataWidth-1:0]  pwdata,
  output logic [txpm_pkg::ApbDataWidth-1:0]  prdata,
  output logic                               pready
);

  localparam int PtIdxWidth = $clog2(NumPoints);
  localparam int LastPt     = NumPoints - 1;

  // sequencer states
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StStart = 3'd1;
  localparam logic [2:0] StScan  = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StAdd   = 3'd4;
  localparam logic [2:0] StDiv   = 3'd5;
  localparam logic [2:0] StFix   = 3'd6;
  localparam logic [2:0] StOut   = 3'd7;

  // --------------------------------------------------------------------------
  // calibration table
  // --------------------------------------------------------------------------
  txpm_pkg::point_t                   cal_q [NumPoints];
  logic [txpm_pkg::RegIdxWidth-1:0]   reg_idx;
  logic                               cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = paddr[txpm_pkg::RegIdxWidth+1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  for (genvar g = 0; g < NumPoints; g++) begin : g_point
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cal_q[g] <= txpm_pkg::PointReset[g];
      end else if (cfg_we && (g < txpm_pkg::NumRegs) &&
                   (reg_idx == txpm_pkg::RegIdxWidth'(g))) begin
        cal_q[g] <= pwdata[txpm_pkg::PointWidth-1:0];
      end
    end
  end

  // read back, zero beyond the implemented points
  always_comb begin
    prdata = '0;
    if ((reg_idx < NumPoints) && (reg_idx < txpm_pkg::NumRegs)) begin
      prdata = txpm_pkg::ApbDataWidth'(cal_q[reg_idx[PtIdxWidth-1:0]]);
    end
  end

  // --------------------------------------------------------------------------
  // sequencer state
  // --------------------------------------------------------------------------
  logic [2:0]              state_q, state_d;
  txpm_pkg::op_t           op_q, op_d;
  logic signed [7:0]       req_q, req_d;
  logic [PtIdxWidth-1:0]   idx_q, idx_d;
  txpm_pkg::point_t        prev_q, prev_d;
  logic signed [7:0]       c0_q, c0_d;
  logic signed [8:0]       dc_q, dc_d;
  logic [7:0]              dt_q, dt_d;
  logic [7:0]              span_q, span_d;
  logic signed [17:0]      prod_q, prod_d;
  logic                    neg_q, neg_d;
  logic [7:0]              latched_q, latched_d;
  logic [7:0]              driven_q, driven_d;
  logic signed [7:0]       res_chip_q, res_chip_d;
  logic                    res_valid_q, res_valid_d;

  // output register
  logic                    out_valid_q, out_valid_d;
  logic signed [7:0]       out_chip_q, out_chip_d;
  logic                    out_cvalid_q, out_cvalid_d;
  logic [7:0]              out_dac_q, out_dac_d;

  // divider
  txpm_pkg::div_req_t      div_req;
  txpm_pkg::div_rsp_t      div_rsp;

  // datapath helpers
  txpm_pkg::point_t        pt_first, pt_last, pt_cur;
  logic signed [7:0]       t0, t1, c0, c1;
  logic signed [8:0]       span9, dt9;
  logic signed [17:0]      num;
  logic signed [17:0]      mag;
  logic signed [17:0]      qs;
  logic signed [18:0]      sum;
  logic                    found;
  logic                    out_free;

  assign pt_first = cal_q[0];
  assign pt_last  = cal_q[LastPt];
  assign pt_cur   = cal_q[idx_q];

  assign t0    = txpm_pkg::pt_total(prev_q);
  assign t1    = txpm_pkg::pt_total(pt_cur);
  assign c0    = txpm_pkg::pt_chip(prev_q);
  assign c1    = txpm_pkg::pt_chip(pt_cur);
  assign span9 = {t1[7], t1} - {t0[7], t0};
  assign dt9   = {req_q[7], req_q} - {t0[7], t0};
  // first segment whose upper total reaches the request, else the last one
  assign found = (req_q <= t1) || (idx_q == PtIdxWidth'(LastPt));

  // rounding: add half the span, then divide the magnitude
  assign num = prod_q + $signed({10'b0, span_q[7:1]});
  assign mag = num[17] ? -num : num;

  // restore the sign of the quotient and add the lower chip power
  assign qs  = neg_q ? -$signed({1'b0, div_rsp.quotient})
                     : $signed({1'b0, div_rsp.quotient});
  assign sum = {{11{c0_q[7]}}, c0_q} + {qs[17], qs};

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    div_req.start    = (state_q == StAdd);
    div_req.dividend = mag[txpm_pkg::DivNumWidth-1:0];
    div_req.divisor  = span_q;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    req_d       = req_q;
    idx_d       = idx_q;
    prev_d      = prev_q;
    c0_d        = c0_q;
    dc_d        = dc_q;
    dt_d        = dt_q;
    span_d      = span_q;
    prod_d      = prod_q;
    neg_d       = neg_q;
    latched_d   = latched_q;
    driven_d    = driven_q;
    res_chip_d  = res_chip_q;
    res_valid_d = res_valid_q;

    out_valid_d  = out_valid_q && out_stall_i;
    out_chip_d   = out_chip_q;
    out_cvalid_d = out_cvalid_q;
    out_dac_d    = out_dac_q;

    case (state_q)
      StIdle: begin
        if (in_valid_i && !in_stall_o) begin
          op_d    = operation_i;
          req_d   = requested_dbm_i;
          state_d = StStart;
        end
      end
      StStart: begin
        res_chip_d  = '0;
        res_valid_d = 1'b0;
        if (op_q == txpm_pkg::OpMap) begin
          res_valid_d = 1'b1;
          if (req_q <= txpm_pkg::pt_total(pt_first)) begin
            // clamp to the first point
            res_chip_d = txpm_pkg::pt_chip(pt_first);
            latched_d  = txpm_pkg::pt_bias(pt_first);
            state_d    = StOut;
          end else if (req_q >= txpm_pkg::pt_total(pt_last)) begin
            // clamp to the last point
            res_chip_d = txpm_pkg::pt_chip(pt_last);
            latched_d  = txpm_pkg::pt_bias(pt_last);
            state_d    = StOut;
          end else begin
            prev_d  = pt_first;
            idx_d   = PtIdxWidth'(1);
            state_d = StScan;
          end
        end else begin
          // transmit enable drives the latched bias, anything else drives 0
          driven_d = (op_q == txpm_pkg::OpTxEnable) ? latched_q : 8'd0;
          state_d  = StOut;
        end
      end
      StScan: begin
        if (found) begin
          latched_d = txpm_pkg::pt_bias(prev_q);
          if (span9 <= 9'sd0) begin
            // flat or falling segment gives the upper chip power
            res_chip_d = c1;
            state_d    = StOut;
          end else begin
            c0_d    = c0;
            dc_d    = {c1[7], c1} - {c0[7], c0};
            dt_d    = dt9[7:0];
            span_d  = span9[7:0];
            state_d = StMul;
          end
        end else begin
          prev_d = pt_cur;
          idx_d  = idx_q + 1'b1;
        end
      end
      StMul: begin
        prod_d  = dc_q * $signed({1'b0, dt_q});
        state_d = StAdd;
      end
      StAdd: begin
        neg_d   = num[17];
        state_d = StDiv;
      end
      StDiv: begin
        if (div_rsp.done) begin
          state_d = StFix;
        end
      end
      StFix: begin
        if (sum > 19'sd127) begin
          res_chip_d = 8'sd127;
        end else if (sum < -19'sd128) begin
          res_chip_d = -8'sd128;
        end else begin
          res_chip_d = sum[7:0];
        end
        state_d = StOut;
      end
      StOut: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_chip_d   = res_chip_q;
          out_cvalid_d = res_valid_q;
          out_dac_d    = driven_q;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      latched_q   <= '0;
      driven_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      latched_q   <= latched_d;
      driven_q    <= driven_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    req_q        <= req_d;
    idx_q        <= idx_d;
    prev_q       <= prev_d;
    c0_q         <= c0_d;
    dc_q         <= dc_d;
    dt_q         <= dt_d;
    span_q       <= span_d;
    prod_q       <= prod_d;
    neg_q        <= neg_d;
    res_chip_q   <= res_chip_d;
    res_valid_q  <= res_valid_d;
    out_chip_q   <= out_chip_d;
    out_cvalid_q <= out_cvalid_d;
    out_dac_q    <= out_dac_d;
  end

  txpm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // busy for the whole request, free only when the sequencer is idle
  assign in_stall_o   = (state_q != StIdle);
  assign out_valid_o  = out_valid_q;
  assign chip_dbm_o   = out_chip_q;
  assign chip_valid_o = out_cvalid_q;
  assign dac_level_o  = out_dac_q;

endmodule

// ===== src/txpm_checker.sv =====
// ----------------------------------------------------------------------------
// txpm_checker
// port-level checks of the transmit power mapper, bound to the top level
// ----------------------------------------------------------------------------
`include "tx_power_map_and_pa_bias_assert.svh"

module txpm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic signed [7:0] chip_dbm_o,
  input logic              chip_valid_o,
  input logic [7:0]        dac_level_o
);

  // non-map results carry a zero chip power
  `TXPM_ASSERT_IMP(a_nomap_zero, clk_i, rst_ni, out_valid_o && !chip_valid_o, chip_dbm_o == 8'sd0, "chip power not zero on a non-map result")

  // a taken request keeps the block busy in the next cycle
  `TXPM_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "request taken while block still free")

  // a fresh result only appears at the end of a request
  `TXPM_ASSERT_IMP(a_result_from_req, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result without a request in flight")

  // a stalled result holds
  `TXPM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(chip_dbm_o) && $stable(chip_valid_o) && $stable(dac_level_o), "stalled result changed")

endmodule

bind tx_power_map_and_pa_bias txpm_checker u_txpm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .chip_dbm_o   (chip_dbm_o),
  .chip_valid_o (chip_valid_o),
  .dac_level_o  (dac_level_o)
);

// ===== tb/tb_tx_power_map_and_pa_bias.sv =====
// ----------------------------------------------------------------------------
// tb_tx_power_map_and_pa_bias
// self-checking bench: requests of every operation against the calibration
// table, with tables reloaded between phases and outputs checked in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tx_power_map_and_pa_bias;

  localparam int            NumPts     = txpm_pkg::NumPointsDef;
  localparam int            LastPt     = NumPts - 1;
  localparam txpm_pkg::op_t OpUnused   = 2'd3;             // spare code, acts as rx/idle
  localparam int            SurplusReg = txpm_pkg::NumRegs; // first index with no register
  localparam int            DrainCycles = 40;               // above the worst map latency
  localparam int            HoldCycles  = 150;
  localparam int            ItemsPerBlock = 130;

  // one result as the bench expects it
  typedef struct packed {
    logic signed [7:0] chip_dbm;
    logic              chip_valid;
    logic [7:0]        dac_level;
  } bias_result_t;

  // --------------------------------------------------------------------------
  // predictor and in-order store of expected results
  // --------------------------------------------------------------------------
  class bias_map_tracker;
    txpm_pkg::point_t cal_point [NumPts];
    logic [7:0]       latched_bias;
    logic [7:0]       driven_bias;
    bias_result_t     expected_q [$];
    int               failures;

    function new();
      for (int i = 0; i < NumPts; i++) cal_point[i] = txpm_pkg::PointReset[i];
      latched_bias = '0;
      driven_bias  = '0;
      failures     = 0;
    endfunction

    function void load_point(int idx, logic [31:0] value);
      if (idx < txpm_pkg::NumRegs && idx < NumPts) cal_point[idx] = value[23:0];
    endfunction

    function int total_of(int i);
      return int'($signed(cal_point[i][7:0]));
    endfunction

    function int chip_of(int i);
      return int'($signed(cal_point[i][15:8]));
    endfunction

    function logic [7:0] bias_of(int i);
      return cal_point[i][23:16];
    endfunction

    function int map_request(int req);
      int seg, t0, c0, c1, span, chip;
      if (req <= total_of(0)) begin
        latched_bias = bias_of(0);
        return chip_of(0);
      end
      if (req >= total_of(LastPt)) begin
        latched_bias = bias_of(LastPt);
        return chip_of(LastPt);
      end
      // first segment whose upper total reaches the request
      seg = 1;
      while (seg < LastPt && req > total_of(seg)) seg++;
      t0   = total_of(seg - 1);
      c0   = chip_of(seg - 1);
      c1   = chip_of(seg);
      span = total_of(seg) - t0;
      latched_bias = bias_of(seg - 1);
      if (span <= 0) return c1;
      chip = c0 + ((c1 - c0) * (req - t0) + span / 2) / span;
      if (chip > 127) chip = 127;
      if (chip < -128) chip = -128;
      return chip;
    endfunction

    function void note_request(txpm_pkg::op_t op, logic signed [7:0] dbm);
      bias_result_t res;
      res.chip_dbm   = '0;
      res.chip_valid = 1'b0;
      case (op)
        txpm_pkg::OpMap: begin
          res.chip_dbm   = 8'(map_request(int'(dbm)));
          res.chip_valid = 1'b1;
        end
        txpm_pkg::OpTxEnable: begin
          driven_bias = latched_bias;
        end
        default: begin
          driven_bias = '0;
        end
      endcase
      res.dac_level = driven_bias;
      expected_q.push_back(res);
    endfunction

    function void report(string field, int exp_v, int act_v);
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
      failures++;
    endfunction

    function void check_result(logic signed [7:0] chip_dbm, logic chip_valid,
                               logic [7:0] dac_level);
      bias_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, chip_dbm %0d chip_valid %0d dac_level %0d",
                 $time, chip_dbm, chip_valid, dac_level);
        failures++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (chip_dbm !== exp_r.chip_dbm)     report("chip_dbm", exp_r.chip_dbm, chip_dbm);
      if (chip_valid !== exp_r.chip_valid) report("chip_valid", exp_r.chip_valid, chip_valid);
      if (dac_level !== exp_r.dac_level)   report("dac_level", exp_r.dac_level, dac_level);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals
  // --------------------------------------------------------------------------
  logic                              clk_i;
  logic                              rst_ni          = 1'b0;
  logic                              in_valid_i      = 1'b0;
  logic                              in_stall_o;
  txpm_pkg::op_t                     operation_i     = txpm_pkg::OpMap;
  logic signed [7:0]                 requested_dbm_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i     = 1'b0;
  logic signed [7:0]                 chip_dbm_o;
  logic                              chip_valid_o;
  logic [7:0]                        dac_level_o;
  logic                              psel            = 1'b0;
  logic                              penable         = 1'b0;
  logic                              pwrite          = 1'b0;
  logic [txpm_pkg::ApbAddrWidth-1:0] paddr           = '0;
  logic [txpm_pkg::ApbDataWidth-1:0] pwdata          = '0;
  logic [txpm_pkg::ApbDataWidth-1:0] prdata;
  logic                              pready;

  bias_map_tracker  tracker = new();
  txpm_pkg::point_t next_table [NumPts];

  // idle odds in percent, changed per phase by the main sequence
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // a bump of hold_seq asks the result side for one long hold-off
  int hold_seq  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  tx_power_map_and_pa_bias u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .requested_dbm_i(requested_dbm_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .chip_dbm_o     (chip_dbm_o),
    .chip_valid_o   (chip_valid_o),
    .dac_level_o    (dac_level_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // result side: check what is taken, then pick the stall for the next cycle
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_result(chip_dbm_o, chip_valid_o, dac_level_o);
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      // long hold-off so the block fills and pushes back on requests
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------
  // offer one request, maybe after a random gap, and wait until it is taken
  task automatic send_request(input txpm_pkg::op_t op, input logic signed [7:0] dbm);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    requested_dbm_i <= dbm;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_request(op, dbm);
  endtask

  // stop offering and let every outstanding result come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // setup then access phase; psel stays high across back-to-back writes
  task automatic write_reg(input int idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= txpm_pkg::ApbAddrWidth'(4 * idx);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tracker.load_point(idx, value);
  endtask

  task automatic bus_idle();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // junk in the top byte must not reach the 24 bit points
  task automatic write_table();
    for (int i = 0; i < NumPts; i++)
      write_reg(i, {8'($urandom()), next_table[i]});
    bus_idle();
  endtask

  // ascending totals with random chip powers and bias codes
  function automatic void build_ordered();
    int totals [$];
    for (int i = 0; i < NumPts; i++) totals.push_back(int'($urandom_range(255)) - 128);
    totals.sort();
    for (int i = 0; i < NumPts; i++)
      next_table[i] = {8'($urandom()), 8'($urandom()), 8'(totals[i])};
  endfunction

  function automatic void build_unordered();
    for (int i = 0; i < NumPts; i++) next_table[i] = 24'($urandom());
  endfunction

  function automatic void build_flat(input txpm_pkg::point_t value);
    for (int i = 0; i < NumPts; i++) next_table[i] = value;
  endfunction

  // totals across the whole range, chips and bias codes swinging end to end
  function automatic void build_wide();
    next_table[0] = {8'd255, 8'sd127,  -8'sd128};
    next_table[1] = {8'd0,   -8'sd128, -8'sd80};
    next_table[2] = {8'd170, 8'sd100,  -8'sd30};
    next_table[3] = {8'd85,  -8'sd100, 8'sd0};
    next_table[4] = {8'd1,   8'sd50,   8'sd40};
    next_table[5] = {8'd254, -8'sd50,  8'sd90};
    next_table[6] = {8'd128, -8'sd128, 8'sd127};
  endfunction

  // mostly within the table's span, sometimes anywhere
  function automatic logic signed [7:0] pick_dbm();
    int lo, hi;
    if ($urandom_range(99) < 35) return 8'($urandom());
    lo = tracker.total_of(0);
    hi = tracker.total_of(LastPt);
    if (lo > hi) begin
      lo = tracker.total_of(LastPt);
      hi = tracker.total_of(0);
    end
    lo = (lo - 3 < -128) ? -128 : lo - 3;
    hi = (hi + 3 > 127) ? 127 : hi + 3;
    return 8'(lo + int'($urandom_range(hi - lo)));
  endfunction

  function automatic txpm_pkg::op_t pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 60) return txpm_pkg::OpMap;
    if (r < 80) return txpm_pkg::OpTxEnable;
    if (r < 95) return txpm_pkg::OpRxIdle;
    return OpUnused;
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed part on the factory table
    send_request(txpm_pkg::OpTxEnable, 8'sd0);   // nothing latched yet, drives 0
    send_request(txpm_pkg::OpMap, -8'sd128);     // clamps to the first point
    send_request(txpm_pkg::OpMap, 8'sd127);      // clamps to the last point
    send_request(txpm_pkg::OpTxEnable, 8'sd0);
    send_request(txpm_pkg::OpMap, 8'sd10);       // exactly on the first point
    send_request(txpm_pkg::OpMap, 8'sd11);
    send_request(txpm_pkg::OpMap, 8'sd14);       // exactly on an inner point
    send_request(txpm_pkg::OpMap, 8'sd29);
    send_request(txpm_pkg::OpTxEnable, -8'sd1);
    send_request(txpm_pkg::OpRxIdle, 8'sd127);
    send_request(txpm_pkg::OpTxEnable, 8'sd0);
    send_request(OpUnused, -8'sd128);            // spare code drops the bias
    send_request(txpm_pkg::OpMap, 8'sd30);       // exactly on the last point
    drain();

    // a write past the last register must leave the table alone
    write_reg(SurplusReg, 32'hFFFF_FFFF);
    bus_idle();
    send_request(txpm_pkg::OpMap, 8'sd127);
    send_request(txpm_pkg::OpTxEnable, 8'sd0);
    drain();

    build_wide();
    write_table();
    send_request(txpm_pkg::OpMap, -8'sd128);
    send_request(txpm_pkg::OpMap, -8'sd127);
    send_request(txpm_pkg::OpMap, 8'sd0);
    send_request(txpm_pkg::OpTxEnable, 8'sd0);
    send_request(txpm_pkg::OpMap, 8'sd126);
    send_request(txpm_pkg::OpMap, 8'sd127);
    send_request(txpm_pkg::OpTxEnable, 8'sd0);
    drain();

    // random part: three idle schemes, five tables each
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 85;
        end
        1: begin
          send_idle_pct = 85;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < 5; blk++) begin
        case (blk)
          0, 4: build_ordered();
          1:    build_unordered();
          2: begin
            if (mode == 0)      build_flat(24'h000000);
            else if (mode == 1) build_flat(24'hFFFFFF);
            else                build_wide();
          end
          default: build_ordered();
        endcase
        write_table();
        if (blk == 0 && mode < 2) hold_seq <= hold_seq + 1;
        repeat (ItemsPerBlock) send_request(pick_op(), pick_dbm());
        drain();
      end
    end

    if (tracker.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, tracker.pending());
      tracker.failures++;
    end
    if (tracker.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
